// ----- hw/rtl/lfu_page_replacement_macros.svh -----
// Assertion macros for the LFU page replacement block.
`ifndef LFU_PAGE_REPLACEMENT_MACROS_SVH
`define LFU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define LFU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lfu assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define LFU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lfu assertion failed");

`endif

// ----- hw/rtl/lfu_pkg.sv -----
// Shared types and constants of the LFU page replacement block.
package lfu_pkg;

	localparam int CNT_W       = 16;
	localparam int FC_W        = 5;
	localparam int IN_W        = 8;
	localparam int OUT_IDX_W   = 4;
	localparam int OUT_PAGE_W  = 8;
	localparam int OUT_DATA_W  = 32;
	localparam logic [CNT_W-1:0] CNT_MAX  = '1;
	localparam logic [FC_W-1:0]  FC_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE
	} lfu_state_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic commit;
	} lfu_cmd_t;

	typedef struct packed {
		logic last_issue;
		logic out_free;
	} lfu_sts_t;

endpackage

// ----- hw/rtl/lfu_page_replacement.sv -----
// Top level of the LFU page replacement block.
// One request is taken at a time; the frames in use (N) are scanned one per cycle.
// An accepted request passes through the scan, drain and update states; the result is registered at commit,
// which waits in the update state until the output register is free; only then is the next request taken.
// Reset clears the frame valid marks, the fault total and sets the frame count to 16.
`include "lfu_page_replacement_macros.svh"

module lfu_page_replacement #(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lfu_pkg::FC_W-1:0]       cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// page[7:0]
	input  logic [lfu_pkg::IN_W-1:0]       s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// hit[0], frame_index[4:1], evicted_valid[5], evicted_page[13:6], fault_total[29:14]
	output logic [lfu_pkg::OUT_DATA_W-1:0] m_tdata
);

	lfu_pkg::lfu_cmd_t cmd;
	lfu_pkg::lfu_sts_t sts;

	lfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lfu_dp #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	`LFU_ASSERT_NXT(a_one_request_at_a_time, s_tvalid && s_tready, !s_tready)
	`LFU_ASSERT_NXT(a_commit_gives_result, cmd.commit, m_tvalid)
	`LFU_ASSERT_IMP(a_no_accept_while_scanning, cmd.issue, !s_tready && !cmd.commit)

endmodule

// ----- hw/rtl/lfu_ctrl.sv -----
// Controller state machine that sequences the frame scan and the update.
module lfu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  lfu_pkg::lfu_sts_t sts,
	output lfu_pkg::lfu_cmd_t cmd
);

	lfu_pkg::lfu_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		s_tready   = 1'b0;
		case (state_q)
			lfu_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d   = lfu_pkg::ST_SCAN;
				end
			end
			lfu_pkg::ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last_issue) begin
					state_d = lfu_pkg::ST_DRAIN;
				end
			end
			lfu_pkg::ST_DRAIN: begin
				state_d = lfu_pkg::ST_UPDATE;
			end
			lfu_pkg::ST_UPDATE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = lfu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lfu_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/lfu_dp.sv -----
// Datapath with frame memories, scan trackers, counters and the result register.
module lfu_dp #(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lfu_pkg::FC_W-1:0]            cfg_wdata,
	input  logic [lfu_pkg::IN_W-1:0]            s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lfu_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  lfu_pkg::lfu_cmd_t                   cmd,
	output lfu_pkg::lfu_sts_t                   sts
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	logic [PAGE_BITS-1:0]         frame_page [FRAMES];
	logic [lfu_pkg::CNT_W-1:0]    use_count  [FRAMES];
	logic [FRAMES-1:0]            valid_q;

	logic [lfu_pkg::FC_W-1:0]     fc_q;
	logic [lfu_pkg::CNT_W-1:0]    fault_q;
	logic [PAGE_BITS-1:0]         page_q;
	logic [IDX_W-1:0]             scan_idx_q;
	logic [IDX_W-1:0]             last_idx;

	logic [PAGE_BITS-1:0]         rd_page_s1;
	logic [lfu_pkg::CNT_W-1:0]    rd_cnt_s1;
	logic [IDX_W-1:0]             cmp_idx_s1;
	logic                         cmp_vld_s1;

	logic                         hit_found_q;
	logic [IDX_W-1:0]             hit_idx_q;
	logic [lfu_pkg::CNT_W-1:0]    hit_cnt_q;
	logic                         empty_found_q;
	logic [IDX_W-1:0]             empty_idx_q;
	logic [lfu_pkg::CNT_W-1:0]    min_cnt_q;
	logic [IDX_W-1:0]             min_idx_q;
	logic [PAGE_BITS-1:0]         min_page_q;

	logic [PAGE_BITS+lfu_pkg::IN_W-1:0]       pg_ext;
	logic                                     cmp_valid;
	logic [IDX_W-1:0]                         slot;
	logic                                     evicted;
	logic [PAGE_BITS+lfu_pkg::OUT_PAGE_W-1:0] ev_ext;
	logic [IDX_W+lfu_pkg::OUT_IDX_W-1:0]      slot_ext;
	logic [lfu_pkg::CNT_W-1:0]                fault_next;
	logic [lfu_pkg::CNT_W-1:0]                cnt_wdata;
	logic                                     out_vld_q;
	logic [lfu_pkg::OUT_DATA_W-1:0]           out_data_q;

	assign pg_ext = {{PAGE_BITS{1'b0}}, s_tdata};

	always_comb begin
		if (fc_q == '0) begin
			last_idx = '0;
		end else if (32'(fc_q) > FRAMES) begin
			last_idx = IDX_W'(FRAMES - 1);
		end else begin
			last_idx = IDX_W'(fc_q - 5'd1);
		end
	end

	assign sts.last_issue = (scan_idx_q == last_idx);
	assign sts.out_free   = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= lfu_pkg::FC_RESET;
		end else if (cfg_we) begin
			fc_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			page_q <= pg_ext[PAGE_BITS-1:0];
		end
		if (cmd.start) begin
			scan_idx_q <= '0;
		end else if (cmd.issue) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
	end

	// Frame memories: one scan read per cycle, one write at commit.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			use_count[slot] <= cnt_wdata;
			if (!hit_found_q) begin
				frame_page[slot] <= page_q;
			end
		end
		rd_page_s1 <= frame_page[scan_idx_q];
		rd_cnt_s1  <= use_count[scan_idx_q];
		cmp_idx_s1 <= scan_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
			valid_q    <= '0;
			fault_q    <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.issue;
			if (cmd.commit) begin
				valid_q[slot] <= 1'b1;
				fault_q       <= fault_next;
				out_vld_q     <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign cmp_valid = valid_q[cmp_idx_s1];

	// Scan trackers: first match, first empty frame, least count with lowest index.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (cmp_vld_s1) begin
			if (!hit_found_q && cmp_valid && (rd_page_s1 == page_q)) begin
				hit_found_q <= 1'b1;
				hit_idx_q   <= cmp_idx_s1;
				hit_cnt_q   <= rd_cnt_s1;
			end
			if (!empty_found_q && !cmp_valid) begin
				empty_found_q <= 1'b1;
				empty_idx_q   <= cmp_idx_s1;
			end
			if ((cmp_idx_s1 == '0) || (rd_cnt_s1 < min_cnt_q)) begin
				min_cnt_q  <= rd_cnt_s1;
				min_idx_q  <= cmp_idx_s1;
				min_page_q <= rd_page_s1;
			end
		end
	end

	always_comb begin
		evicted   = 1'b0;
		cnt_wdata = {{(lfu_pkg::CNT_W-1){1'b0}}, 1'b1};
		if (hit_found_q) begin
			slot = hit_idx_q;
			if (hit_cnt_q != lfu_pkg::CNT_MAX) begin
				cnt_wdata = hit_cnt_q + 1'b1;
			end else begin
				cnt_wdata = hit_cnt_q;
			end
		end else if (empty_found_q) begin
			slot = empty_idx_q;
		end else begin
			slot    = min_idx_q;
			evicted = 1'b1;
		end
		if (!hit_found_q && (fault_q != lfu_pkg::CNT_MAX)) begin
			fault_next = fault_q + 1'b1;
		end else begin
			fault_next = fault_q;
		end
	end

	assign ev_ext   = {{lfu_pkg::OUT_PAGE_W{1'b0}}, (evicted ? min_page_q : '0)};
	assign slot_ext = {{lfu_pkg::OUT_IDX_W{1'b0}}, slot};

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data_q <= {2'b00, fault_next, ev_ext[lfu_pkg::OUT_PAGE_W-1:0], evicted,
				slot_ext[lfu_pkg::OUT_IDX_W-1:0], hit_found_q};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for the LFU page replacement block with a frame-table scoreboard and stream drivers.

class lfu_scoreboard;
	typedef struct packed {
		logic [lfu_pkg::CNT_W-1:0]      fault_total;
		logic [lfu_pkg::OUT_PAGE_W-1:0] evicted_page;
		logic                           evicted_valid;
		logic [lfu_pkg::OUT_IDX_W-1:0]  frame_index;
		logic                           hit;
	} outcome_t;

	logic [lfu_pkg::IN_W-1:0]  resident_page[16];
	bit                        resident[16];
	logic [lfu_pkg::CNT_W-1:0] use_cnt[16];
	logic [lfu_pkg::CNT_W-1:0] faults;
	logic [lfu_pkg::FC_W-1:0]  frame_count;
	outcome_t                  outcome_q[$];
	int                        errors;

	function new();
		for (int i = 0; i < 16; i++) begin
			resident_page[i] = '0;
			resident[i] = 1'b0;
			use_cnt[i] = '0;
		end
		faults = '0;
		frame_count = lfu_pkg::FC_RESET;
		errors = 0;
	endfunction

	function void set_frame_count(logic [lfu_pkg::FC_W-1:0] value);
		frame_count = value;
	endfunction

	// Looks the page up among the active frames, updates the frame table and queues the outcome of the request.
	function void reference_page(logic [lfu_pkg::IN_W-1:0] pg);
		outcome_t o;
		int n;
		int slot;
		bit found;
		o = '0;
		slot = 0;
		found = 1'b0;
		n = (frame_count == 0) ? 1 : ((frame_count > 16) ? 16 : int'(frame_count));
		for (int i = 0; i < n; i++) begin
			if (!found && resident[i] && resident_page[i] == pg) begin
				found = 1'b1;
				slot = i;
			end
		end
		if (found) begin
			o.hit = 1'b1;
			if (use_cnt[slot] != lfu_pkg::CNT_MAX)
				use_cnt[slot]++;
		end else begin
			if (faults != lfu_pkg::CNT_MAX)
				faults++;
			for (int i = 0; i < n; i++) begin
				if (!found && !resident[i]) begin
					found = 1'b1;
					slot = i;
				end
			end
			if (!found) begin
				slot = 0;
				for (int i = 1; i < n; i++) begin
					if (use_cnt[i] < use_cnt[slot])
						slot = i;
				end
				o.evicted_valid = 1'b1;
				o.evicted_page = resident_page[slot];
			end
			resident_page[slot] = pg;
			resident[slot] = 1'b1;
			use_cnt[slot] = 1;
		end
		o.frame_index = 4'(slot);
		o.fault_total = faults;
		outcome_q.push_back(o);
	endfunction

	task report(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		errors++;
	endtask

	task check_result(logic [lfu_pkg::OUT_DATA_W-1:0] data);
		outcome_t got;
		outcome_t want;
		got = data[29:0];
		if (outcome_q.size() == 0) begin
			report($sformatf("result %h arrived with nothing expected", data));
			return;
		end
		want = outcome_q.pop_front();
		if (got.hit !== want.hit)
			report($sformatf("hit %b, expected %b", got.hit, want.hit));
		if (got.frame_index !== want.frame_index)
			report($sformatf("frame_index %0d, expected %0d", got.frame_index,
				want.frame_index));
		if (got.evicted_valid !== want.evicted_valid)
			report($sformatf("evicted_valid %b, expected %b", got.evicted_valid,
				want.evicted_valid));
		if (got.evicted_page !== want.evicted_page)
			report($sformatf("evicted_page %h, expected %h", got.evicted_page,
				want.evicted_page));
		if (got.fault_total !== want.fault_total)
			report($sformatf("fault_total %0d, expected %0d", got.fault_total,
				want.fault_total));
	endtask
endclass

module testbench;
	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [lfu_pkg::FC_W-1:0]       cfg_wdata;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [lfu_pkg::IN_W-1:0]       s_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [lfu_pkg::OUT_DATA_W-1:0] m_tdata;

	int src_idle;
	int sink_idle;
	int hold_left;
	lfu_scoreboard board;

	logic [lfu_pkg::IN_W-1:0]  warmup[11] = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd170,
		8'd85, 8'd1, 8'd85, 8'd2, 8'd170};
	logic [lfu_pkg::FC_W-1:0]  seg_fc[12] = '{5'd1, 5'd0, 5'd5, 5'd16, 5'd31, 5'd2,
		5'd20, 5'd8, 5'd12, 5'd3, 5'd17, 5'd16};

	lfu_page_replacement DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_page(input logic [lfu_pkg::IN_W-1:0] pg);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pg;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.reference_page(pg);
		@(negedge clk);
	endtask

	task automatic write_frame_count(input logic [lfu_pkg::FC_W-1:0] value);
		s_tvalid <= 1'b0;
		while (board.outcome_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		board.set_frame_count(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [lfu_pkg::IN_W-1:0] pick_page(logic [lfu_pkg::IN_W-1:0] base,
		int span);
		if ($urandom_range(99) < 10)
			return 8'($urandom_range(255));
		return base + 8'($urandom_range(span) % ($urandom_range(span) + 1));
	endfunction

	initial begin
		int seg;
		int k;
		int span;
		logic [lfu_pkg::IN_W-1:0] base;
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		src_idle = 21;
		sink_idle = 49;
		hold_left = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_frame_count(5'd4);
		foreach (warmup[i])
			send_page(warmup[i]);
		// Page 85 sits in a frame outside the two active ones, so it faults here.
		write_frame_count(5'd2);
		send_page(8'd85);
		write_frame_count(5'd4);
		send_page(8'd85);
		send_page(8'd3);
		write_frame_count(5'd0);
		send_page(8'd7);
		send_page(8'd7);
		write_frame_count(5'd31);
		for (k = 0; k < 5; k++)
			send_page(8'(9 + k));

		for (seg = 0; seg < 12; seg++) begin
			if (seg == 4) begin
				src_idle = 49;
				sink_idle = 21;
			end
			if (seg == 8) begin
				src_idle = 0;
				sink_idle = 0;
			end
			write_frame_count(seg_fc[seg]);
			span = (seg_fc[seg] == 0) ? 1 : ((seg_fc[seg] > 16) ? 16 : int'(seg_fc[seg]));
			span = span + 2;
			base = 8'($urandom_range(255));
			if (seg == 2 || seg == 9)
				hold_left = 300;
			for (k = 0; k < 50; k++)
				send_page(pick_page(base, span));
		end

		s_tvalid <= 1'b0;
		while (board.outcome_q.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
		if (board.errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end
endmodule
